// ----- sv/pwsl_pkg.sv -----
// Shared types and constants for the piecewise-linear sensor linearizer.
// Holds the breakpoint curve, datapath widths and the controller/datapath
// command and status structs. No dependencies.
package pwsl_pkg;

  localparam int POINTS    = 17;
  localparam int ADC_W     = 10;
  localparam int LUX_W     = 11;
  localparam int IDX_W     = $clog2(POINTS);
  localparam int PROD0_W   = LUX_W + ADC_W;       // l0 * dadc, unsigned
  localparam int PROD1_W   = LUX_W + ADC_W + 2;   // dlux * dx, signed
  localparam int NUM_W     = PROD1_W + 1;
  localparam int DIV_STEPS = NUM_W / 2;           // two quotient bits a cycle
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);

  localparam logic [ADC_W-1:0] ADC_TAB [POINTS] = '{
    10'd304, 10'd316, 10'd338, 10'd353, 10'd372, 10'd465, 10'd496,
    10'd564, 10'd567, 10'd592, 10'd617, 10'd648, 10'd697, 10'd744,
    10'd778, 10'd818, 10'd883
  };

  localparam logic [LUX_W-1:0] LUX_TAB [POINTS] = '{
    11'd40,  11'd60,  11'd80,  11'd100, 11'd150, 11'd200, 11'd250,
    11'd300, 11'd350, 11'd400, 11'd450, 11'd500, 11'd600, 11'd700,
    11'd800, 11'd900, 11'd1000
  };

  typedef struct packed {
    logic load;
    logic search;
    logic mul;
    logic div_init;
    logic div_step;
    logic out_write;
  } pwsl_cmd_t;

  typedef struct packed {
    logic search_done;
    logic div_done;
    logic out_full;
  } pwsl_stat_t;

endpackage

// ----- sv/pwsl_dp.sv -----
// Datapath of the linearizer: segment search index, product registers,
// radix-4 restoring divider and the output register.
// Depends on pwsl_pkg.
module pwsl_dp
  import pwsl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  pwsl_cmd_t        cmd,
  output pwsl_stat_t       stat,
  input  logic [ADC_W-1:0] adc_sample,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [LUX_W-1:0] lux
);

  logic [ADC_W-1:0]          sample;
  logic [IDX_W-1:0]          k;
  logic [PROD0_W-1:0]        p0;
  logic signed [PROD1_W-1:0] p1;
  logic [ADC_W-1:0]          den;
  logic [LUX_W-1:0]          l0;
  logic                      degen;
  logic                      neg;
  logic [ADC_W-1:0]          rem;
  logic [NUM_W-1:0]          dvd;
  logic [CNT_W-1:0]          dcnt;

  logic [IDX_W-1:0]          seg;
  logic [IDX_W-1:0]          seg_prev;
  logic [ADC_W-1:0]          a0, a1;
  logic [LUX_W-1:0]          l0_sel, l1_sel;
  logic signed [ADC_W:0]     den_s;
  logic signed [ADC_W:0]     dx_s;
  logic signed [LUX_W:0]     dlux_s;
  logic signed [NUM_W-1:0]   num;
  logic [ADC_W:0]            t1, t2, r1, r2;
  logic                      q1, q2;
  logic [LUX_W-1:0]          result;

  assign stat.search_done = (sample <= ADC_TAB[k]) || (k == LAST_IDX);
  assign stat.div_done    = (dcnt == '0);
  assign stat.out_full    = out_valid && !out_ready;

  // Readings at or below the first breakpoint use the first segment.
  always_comb begin
    seg      = (k == '0) ? IDX_W'(1) : k;
    seg_prev = seg - IDX_W'(1);
    a0       = ADC_TAB[seg_prev];
    a1       = ADC_TAB[seg];
    l0_sel   = LUX_TAB[seg_prev];
    l1_sel   = LUX_TAB[seg];
    den_s    = $signed({1'b0, a1}) - $signed({1'b0, a0});
    dx_s     = $signed({1'b0, sample}) - $signed({1'b0, a0});
    dlux_s   = $signed({1'b0, l1_sel}) - $signed({1'b0, l0_sel});
  end

  assign num = $signed({{(NUM_W - PROD0_W){1'b0}}, p0})
             + $signed({{(NUM_W - PROD1_W){p1[PROD1_W-1]}}, p1});

  // Two restoring subtract steps per cycle.
  always_comb begin
    t1 = {rem, dvd[NUM_W-1]};
    q1 = (t1 >= {1'b0, den});
    r1 = q1 ? (t1 - {1'b0, den}) : t1;
    t2 = {r1[ADC_W-1:0], dvd[NUM_W-2]};
    q2 = (t2 >= {1'b0, den});
    r2 = q2 ? (t2 - {1'b0, den}) : t2;
  end

  always_comb begin
    if (degen) begin
      result = l0;
    end else if (neg) begin
      result = '0;
    end else if (|dvd[NUM_W-1:LUX_W]) begin
      result = '1;
    end else begin
      result = dvd[LUX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample <= adc_sample;
    end
    if (cmd.load) begin
      k <= '0;
    end else if (cmd.search && !stat.search_done) begin
      k <= k + IDX_W'(1);
    end
    if (cmd.mul) begin
      p0    <= l0_sel * den_s[ADC_W-1:0];
      p1    <= PROD1_W'(dlux_s) * PROD1_W'(dx_s);
      den   <= den_s[ADC_W-1:0];
      l0    <= l0_sel;
      degen <= den_s[ADC_W] || (den_s == '0);
    end
    if (cmd.div_init) begin
      neg <= num[NUM_W-1];
      dvd <= num;
      rem <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[NUM_W-3:0], q1, q2};
      rem <= r2[ADC_W-1:0];
    end
    if (cmd.out_write) begin
      lux <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.div_init) begin
        dcnt <= CNT_W'(DIV_STEPS);
      end else if (cmd.div_step) begin
        dcnt <= dcnt - CNT_W'(1);
      end
      if (cmd.out_write) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/pwsl_ctrl.sv -----
// Controller state machine of the linearizer: sequences load, segment
// search, multiply, divide and result write. Depends on pwsl_pkg.
module pwsl_ctrl
  import pwsl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  pwsl_stat_t stat,
  output pwsl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SEARCH = 6'b000010,
    ST_MUL    = 6'b000100,
    ST_PREP   = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_FINISH = 6'b100000
  } pwsl_state_t;

  pwsl_state_t state, state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (stat.search_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_next = ST_FINISH;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_FINISH: begin
        // Hold the result until the output register can take it.
        if (!stat.out_full) begin
          cmd.out_write = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/piecewise_linear_sensor_linearizer_top.sv -----
// Top level of the piecewise-linear light sensor linearizer.
// Depends on pwsl_pkg, pwsl_ctrl and pwsl_dp.
//
// Usage: one 10-bit converter reading enters on adc_sample with in_valid and
// in_ready; one 11-bit illuminance value leaves on lux with out_valid and
// out_ready. Each input transfer yields exactly one output transfer.
// The reading is mapped through a fixed 17-point curve: a serial search finds
// the segment, then lux0 + dlux*(sample-adc0)/dadc is formed exactly and
// floored, with negative values clamped to zero.
// From an input transfer the controller steps through segment search (one
// breakpoint compared per cycle), a multiply state, a divider setup state,
// the radix-4 divider and a state that writes the output register.
// One item is worked on at a time: the next reading is taken only after the
// result of the last one has been handed to the output register; in_ready
// is high only while the controller is idle.
// The output register lets a new reading be accepted while a finished
// result still waits. If the receiver stalls, the next result waits in the
// controller until the output register frees up.
// Reset clears the controller, the divider counter and out_valid; all other
// registers are loaded anew for each item.
module piecewise_linear_sensor_linearizer_top
  import pwsl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ADC_W-1:0] adc_sample,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [LUX_W-1:0] lux
);

  pwsl_cmd_t  cmd;
  pwsl_stat_t stat;

  pwsl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pwsl_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .adc_sample (adc_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .lux        (lux)
  );

endmodule

// ----- sv/pwsl_checker.sv -----
// Port-level checker for the linearizer top level, attached by bind.
// Depends on pwsl_pkg and piecewise_linear_sensor_linearizer_top.
module pwsl_checker
  import pwsl_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [LUX_W-1:0] lux
);

  // A stalled result keeps its value until the transfer.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(lux))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // The block works on one reading at a time.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second reading accepted while busy");

  // No result can appear right after a transfer into an empty block.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared without computation");

  // The fixed curve never maps beyond its top extrapolated value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> lux <= LUX_W'(1215))
    else $error("lux out of curve range");

endmodule

bind piecewise_linear_sensor_linearizer_top pwsl_checker u_pwsl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .lux       (lux)
);

// ----- test/piecewise_linear_sensor_linearizer_top_tb.sv -----
// Testbench for piecewise_linear_sensor_linearizer_top: converter readings in, lux out.
// Checks every result against a predictor of the 17-point curve in this file.
// Depends on pwsl_pkg and the linearizer RTL.
module piecewise_linear_sensor_linearizer_top_tb;
  import pwsl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_POINTS    = 17;
  localparam int LUX_SAT       = (1 << LUX_W) - 1;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 40;

  localparam int CURVE_ADC [NUM_POINTS] = '{
    304, 316, 338, 353, 372, 465, 496, 564, 567, 592, 617, 648, 697, 744, 778, 818, 883
  };
  localparam int CURVE_LUX [NUM_POINTS] = '{
    40, 60, 80, 100, 150, 200, 250, 300, 350, 400, 450, 500, 600, 700, 800, 900, 1000
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [ADC_W-1:0] adc_sample = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [LUX_W-1:0] lux;

  logic [LUX_W-1:0] lux_expected [$];
  int               in_idle_pct = 0;
  int               out_idle_pct = 0;
  int               errors = 0;
  int               quiet_cycles = 0;

  piecewise_linear_sensor_linearizer_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .adc_sample (adc_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .lux        (lux)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Segment search, exact interpolation, floor, clamp at zero and saturation.
  function automatic logic [LUX_W-1:0] interpolate_lux(input logic [ADC_W-1:0] reading);
    int seg;
    int a0;
    int l0;
    int dadc;
    int num;
    int quot;
    seg = 0;
    while (seg < NUM_POINTS && int'(reading) > CURVE_ADC[seg]) seg++;
    if (seg == 0) seg = 1;
    else if (seg == NUM_POINTS) seg = NUM_POINTS - 1;
    a0   = CURVE_ADC[seg-1];
    l0   = CURVE_LUX[seg-1];
    dadc = CURVE_ADC[seg] - a0;
    if (dadc <= 0) begin
      quot = l0;
    end else begin
      num = l0 * dadc + (CURVE_LUX[seg] - l0) * (int'(reading) - a0);
      if (num < 0) return '0;
      quot = num / dadc;
    end
    if (quot > LUX_SAT) quot = LUX_SAT;
    return LUX_W'(quot);
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
    errors++;
  endtask

  // Expected values are queued at the input transfer and consumed at the output one.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) lux_expected.push_back(interpolate_lux(adc_sample));
      if (out_valid && out_ready) begin
        if (lux_expected.size() == 0) report_mismatch("lux with nothing pending", -1, lux);
        else begin
          logic [LUX_W-1:0] want;
          want = lux_expected.pop_front();
          if (lux !== want) report_mismatch("lux", want, lux);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("piecewise_linear_sensor_linearizer_top test failed");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  task automatic send_reading(input logic [ADC_W-1:0] value);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    adc_sample <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (lux_expected.size() != 0) @(posedge clk);
  endtask

  // Lower extrapolation down to the clamp at zero, and upper extrapolation to full scale.
  task automatic test_extrapolation();
    send_reading(10'd0);
    send_reading(10'd279);
    send_reading(10'd280);
    send_reading(10'd303);
    send_reading(10'd884);
    send_reading(10'd1023);
    drain_results();
  endtask

  // A reading exactly on a breakpoint must return that breakpoint's lux.
  task automatic test_breakpoints();
    for (int i = 0; i < NUM_POINTS; i++) send_reading(ADC_W'(CURVE_ADC[i]));
    drain_results();
  endtask

  task automatic test_random_readings(input int count);
    int pick;
    int val;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(3);
      if (pick == 0) val = $urandom_range(1023);
      else if (pick == 1) val = CURVE_ADC[$urandom_range(NUM_POINTS - 1)] + $urandom_range(4) - 2;
      else val = $urandom_range(950, 270);
      send_reading(ADC_W'(val));
    end
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    in_idle_pct  = 23;
    out_idle_pct = 73;
    test_extrapolation();
    test_breakpoints();
    test_random_readings(600);
    in_idle_pct  = 73;
    out_idle_pct = 23;
    test_random_readings(600);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_readings(500);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (lux_expected.size() != 0) report_mismatch("results still pending", 0,
                                                  lux_expected.size());
    if (errors == 0) $display("piecewise_linear_sensor_linearizer_top test passed");
    else $display("piecewise_linear_sensor_linearizer_top test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/pwsl_pkg.sv
sv/pwsl_dp.sv
sv/pwsl_ctrl.sv
sv/piecewise_linear_sensor_linearizer_top.sv
sv/pwsl_checker.sv
test/piecewise_linear_sensor_linearizer_top_tb.sv
